// ----- rtl/psrd_pkg.sv -----
package psrd_pkg;

    localparam int COORD_W = 20;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 64;
    localparam int K_W     = 6;
    localparam int MAG_W   = COORD_W + 1;
    localparam int T_W     = MAG_W + SCALE_W;
    localparam int PT_W    = 3 * COORD_W;
    localparam int ROOT_W  = 36;
    localparam int REM_W   = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_CENTER  = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAREST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 2'd3;

    typedef enum logic [1:0] {CMD_CENTER, CMD_ADD, CMD_COMPUTE} cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic                        ref_set;
        logic signed [COORD_W-1:0]   z;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   x;
    } cmd_t;

    typedef struct packed {
        logic [K_W-1:0]     nearest_count;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [SCALE_W-1:0] scale_z;
    } cfg_t;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W:0] d);
        logic [COORD_W-1:0] r;
        if (d[COORD_W] != d[COORD_W-1])
            r = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            r = d[COORD_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/psrd_ram.sv -----
module psrd_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/psrd_front.sv -----
module psrd_front
    import psrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic                 which_set,
    input  logic [COORD_W-1:0]   x_coord,
    input  logic [COORD_W-1:0]   y_coord,
    input  logic [COORD_W-1:0]   z_coord,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);
    cmd_t       q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       known, push, pop;

    always_comb
    begin
        known = 1'b1;
        dec.kind = CMD_CENTER;
        unique case (operation)
            OP_CENTER:  dec.kind = CMD_CENTER;
            OP_ADD:     dec.kind = CMD_ADD;
            OP_COMPUTE: dec.kind = CMD_COMPUTE;
            default:    known = 1'b0;
        endcase
        dec.ref_set = which_set;
        dec.x = x_coord;
        dec.y = y_coord;
        dec.z = z_coord;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    // unknown operations are taken and dropped here
    assign push      = in_valid && in_ready && known;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ----- rtl/psrd_back.sv -----
module psrd_back
    import psrd_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int DIMENSIONS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          robust_distance,
    output logic                 empty_flag
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int MW = (CW > K_W) ? CW : K_W;
    localparam logic [1:0] LAST_AXIS = 2'(DIMENSIONS - 1);
    localparam logic [5:0] LAST_STEP = 6'(ROOT_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_Q_RD, S_Q_LAT, S_R_RD, S_R_LAT, S_MUL, S_SQ, S_BEST,
        S_SEL_RD, S_SEL_DAT, S_SEL_ADD, S_SQRT, S_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [COORD_W-1:0] qc_x_reg, qc_y_reg, qc_z_reg;
    logic [COORD_W-1:0] rc_x_reg, rc_y_reg, rc_z_reg;
    logic [CW-1:0]      qcnt_reg, rcnt_reg;
    logic [CW-1:0]      i_reg, j_reg, p_reg;
    logic [PT_W-1:0]    qpt_reg, rpt_reg;
    logic [1:0]         axis_reg;
    logic [T_W-1:0]     t_reg;
    logic [DIST_W-1:0]  acc_reg, best_reg, cand_reg, sum_reg;
    logic               have_reg;
    logic [AW-1:0]      cidx_reg;
    logic [MAX_POINTS-1:0] used_reg;
    logic [K_W-1:0]     m_reg, sel_reg;
    logic [DIST_W-1:0]  sh_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [5:0]         step_reg;
    logic [ROOT_W-1:0]  dq_reg;
    logic [K_W:0]       drem_reg;
    logic               out_valid_reg;
    logic [31:0]        dist_reg;
    logic               empty_reg;
    logic [31:0]        res_reg;
    logic               res_empty_reg;

    // point stores and minima
    logic               qw_en, rw_en, mw_en;
    logic [PT_W-1:0]    pt_wdata, q_rdata, r_rdata;
    logic [DIST_W-1:0]  m_rdata, best_min;

    psrd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_qram (
        .clk(clk), .we(qw_en), .waddr(qcnt_reg[AW-1:0]), .wdata(pt_wdata),
        .raddr(i_reg[AW-1:0]), .rdata(q_rdata)
    );
    psrd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_rram (
        .clk(clk), .we(rw_en), .waddr(rcnt_reg[AW-1:0]), .wdata(pt_wdata),
        .raddr(j_reg[AW-1:0]), .rdata(r_rdata)
    );
    psrd_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_mram (
        .clk(clk), .we(mw_en), .waddr(i_reg[AW-1:0]), .wdata(best_min),
        .raddr(p_reg[AW-1:0]), .rdata(m_rdata)
    );

    // centred coordinates for an add
    logic [COORD_W-1:0] cx, cy, cz;
    always_comb
    begin
        cx = cmd.ref_set ? rc_x_reg : qc_x_reg;
        cy = cmd.ref_set ? rc_y_reg : qc_y_reg;
        cz = cmd.ref_set ? rc_z_reg : qc_z_reg;
        pt_wdata = {sat_coord({cmd.z[COORD_W-1], cmd.z} - {cz[COORD_W-1], cz}),
                    sat_coord({cmd.y[COORD_W-1], cmd.y} - {cy[COORD_W-1], cy}),
                    sat_coord({cmd.x[COORD_W-1], cmd.x} - {cx[COORD_W-1], cx})};
    end

    logic is_add, q_full, r_full, sets_empty;
    assign is_add     = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == CMD_ADD);
    assign q_full     = (qcnt_reg == CW'(MAX_POINTS));
    assign r_full     = (rcnt_reg == CW'(MAX_POINTS));
    assign qw_en      = is_add && !cmd.ref_set && !q_full;
    assign rw_en      = is_add && cmd.ref_set && !r_full;
    assign sets_empty = (qcnt_reg == '0) || (rcnt_reg == '0);
    assign cmd_ready  = (state_reg == S_IDLE);

    // per-axis magnitude times scale
    logic [COORD_W-1:0] qa, ra;
    logic [SCALE_W-1:0] sa;
    logic [MAG_W-1:0]   diff, mag;
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin qa = qpt_reg[COORD_W-1:0];           ra = rpt_reg[COORD_W-1:0];
                           sa = cfg.scale_x; end
            2'd1:    begin qa = qpt_reg[2*COORD_W-1:COORD_W];   ra = rpt_reg[2*COORD_W-1:COORD_W];
                           sa = cfg.scale_y; end
            default: begin qa = qpt_reg[PT_W-1:2*COORD_W];      ra = rpt_reg[PT_W-1:2*COORD_W];
                           sa = cfg.scale_z; end
        endcase
        diff = {ra[COORD_W-1], ra} - {qa[COORD_W-1], qa};
        mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    end

    logic [DIST_W-1:0] term;
    assign term = (t_reg[T_W-1:32] != '0) ? {DIST_W{1'b1}}
                                          : (t_reg[31:0] * t_reg[31:0]);
    assign best_min = (acc_reg < best_reg) ? acc_reg : best_reg;
    assign mw_en    = (state_reg == S_BEST) && ((j_reg + 1'b1) == rcnt_reg);

    // k clamp and m = min(k, query count)
    logic [K_W-1:0] k_eff, m_calc;
    always_comb
    begin
        k_eff  = (cfg.nearest_count == '0) ? K_W'(1) : cfg.nearest_count;
        m_calc = (MW'(qcnt_reg) > MW'(k_eff)) ? k_eff : K_W'(qcnt_reg);
    end

    logic [DIST_W-1:0] sum_next;
    assign sum_next = sat_add(sum_reg, cand_reg);

    // one restoring square root step
    logic [REM_W-1:0]  rem_sh, trial, rem_step;
    logic [ROOT_W-1:0] root_step;
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], sh_reg[DIST_W-1:DIST_W-2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_step  = rem_sh - trial;
            root_step = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_step  = rem_sh;
            root_step = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // one restoring division step, one quotient bit a cycle
    logic [K_W:0]      drem_sh, drem_step;
    logic [ROOT_W-1:0] dq_step;
    always_comb
    begin
        drem_sh = {drem_reg[K_W-1:0], dq_reg[ROOT_W-1]};
        if (drem_sh >= {1'b0, m_reg})
        begin
            drem_step = drem_sh - {1'b0, m_reg};
            dq_step   = {dq_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            drem_step = drem_sh;
            dq_step   = {dq_reg[ROOT_W-2:0], 1'b0};
        end
    end

    logic sel_take;
    assign sel_take = !used_reg[p_reg[AW-1:0]] && (!have_reg || (m_rdata < cand_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (cmd_valid && cmd.kind == CMD_COMPUTE)
                    state_next = sets_empty ? S_OUT : S_Q_RD;
            S_Q_RD:    state_next = S_Q_LAT;
            S_Q_LAT:   state_next = S_R_RD;
            S_R_RD:    state_next = S_R_LAT;
            S_R_LAT:   state_next = S_MUL;
            S_MUL:     state_next = S_SQ;
            S_SQ:      state_next = (axis_reg == LAST_AXIS) ? S_BEST : S_MUL;
            S_BEST:
                if ((j_reg + 1'b1) != rcnt_reg)
                    state_next = S_R_RD;
                else if ((i_reg + 1'b1) != qcnt_reg)
                    state_next = S_Q_RD;
                else
                    state_next = S_SEL_RD;
            S_SEL_RD:  state_next = S_SEL_DAT;
            S_SEL_DAT: state_next = ((p_reg + 1'b1) == qcnt_reg) ? S_SEL_ADD : S_SEL_RD;
            S_SEL_ADD: state_next = ((sel_reg + 1'b1) == m_reg) ? S_SQRT : S_SEL_RD;
            S_SQRT:    state_next = (step_reg == LAST_STEP) ? S_DIV : S_SQRT;
            S_DIV:     state_next = (step_reg == LAST_STEP) ? S_OUT : S_DIV;
            S_OUT:     state_next = (!out_valid_reg || out_ready) ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qcnt_reg      <= '0;
            rcnt_reg      <= '0;
            qc_x_reg      <= '0;
            qc_y_reg      <= '0;
            qc_z_reg      <= '0;
            rc_x_reg      <= '0;
            rc_y_reg      <= '0;
            rc_z_reg      <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            axis_reg      <= '0;
            sel_reg       <= '0;
            step_reg      <= '0;
            have_reg      <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (cmd_valid)
                    begin
                        case (cmd.kind)
                            CMD_CENTER:
                                if (cmd.ref_set)
                                begin
                                    rc_x_reg <= cmd.x; rc_y_reg <= cmd.y; rc_z_reg <= cmd.z;
                                end
                                else
                                begin
                                    qc_x_reg <= cmd.x; qc_y_reg <= cmd.y; qc_z_reg <= cmd.z;
                                end
                            CMD_ADD:
                            begin
                                if (qw_en) qcnt_reg <= qcnt_reg + 1'b1;
                                if (rw_en) rcnt_reg <= rcnt_reg + 1'b1;
                            end
                            default:
                            begin
                                i_reg         <= '0;
                                m_reg         <= m_calc;
                                res_reg       <= '0;
                                res_empty_reg <= sets_empty;
                            end
                        endcase
                    end
                S_Q_LAT:
                begin
                    qpt_reg  <= q_rdata;
                    best_reg <= {DIST_W{1'b1}};
                    j_reg    <= '0;
                end
                S_R_LAT:
                begin
                    rpt_reg  <= r_rdata;
                    axis_reg <= '0;
                    acc_reg  <= '0;
                end
                S_MUL:
                    t_reg <= mag * sa;
                S_SQ:
                begin
                    acc_reg <= sat_add(acc_reg, term);
                    if (axis_reg != LAST_AXIS)
                        axis_reg <= axis_reg + 2'd1;
                end
                S_BEST:
                begin
                    best_reg <= best_min;
                    if ((j_reg + 1'b1) != rcnt_reg)
                        j_reg <= j_reg + 1'b1;
                    else if ((i_reg + 1'b1) != qcnt_reg)
                        i_reg <= i_reg + 1'b1;
                    else
                    begin
                        used_reg <= '0;
                        sel_reg  <= '0;
                        sum_reg  <= '0;
                        p_reg    <= '0;
                        have_reg <= 1'b0;
                    end
                end
                S_SEL_DAT:
                begin
                    if (sel_take)
                    begin
                        cand_reg <= m_rdata;
                        cidx_reg <= p_reg[AW-1:0];
                        have_reg <= 1'b1;
                    end
                    if ((p_reg + 1'b1) != qcnt_reg)
                        p_reg <= p_reg + 1'b1;
                end
                S_SEL_ADD:
                begin
                    sum_reg            <= sum_next;
                    used_reg[cidx_reg] <= 1'b1;
                    sel_reg            <= sel_reg + 1'b1;
                    p_reg              <= '0;
                    have_reg           <= 1'b0;
                    sh_reg             <= sum_next;
                    rem_reg            <= '0;
                    root_reg           <= '0;
                    step_reg           <= '0;
                end
                S_SQRT:
                begin
                    rem_reg  <= rem_step;
                    root_reg <= root_step;
                    sh_reg   <= {sh_reg[DIST_W-3:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        dq_reg   <= root_step;
                        drem_reg <= '0;
                        step_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    dq_reg   <= dq_step;
                    drem_reg <= drem_step;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == LAST_STEP)
                        res_reg <= (dq_step[ROOT_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                : dq_step[31:0];
                end
                S_OUT:
                    // output register takes the result once the previous one is gone
                    if (!out_valid_reg || out_ready)
                    begin
                        dist_reg  <= res_reg;
                        empty_reg <= res_empty_reg;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign robust_distance = dist_reg;
    assign empty_flag      = empty_reg;
endmodule

// ----- rtl/point_set_robust_distance.sv -----
// Channel   Handshake                 Payload
// in        in_valid / in_ready       operation, which_set, x_coord, y_coord, z_coord
// out       out_valid / out_ready     robust_distance, empty_flag
// cfg       cfg_we                    cfg_index, cfg_data
//
// Load items (center, add point) go through a two-entry queue and sustain
// one transfer per cycle while the back end is idle, not running a compute.
// A compute walks every query/reference pair on the point RAM read ports,
// sums the m = min(k, Q) smallest per-query minima (Q, R set sizes), then
// runs the bit-serial root and divide before out_valid.
// An empty set goes straight to the output.
// Reset is asynchronous: counts and centers go to zero, no clearing pass.
// A finished result waits in the output register; once a second one waits
// in S_OUT, the queue takes up to two more transfers, then in_ready drops.
module point_set_robust_distance
    import psrd_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int DIMENSIONS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic                 which_set,
    input  logic [COORD_W-1:0]   x_coord,
    input  logic [COORD_W-1:0]   y_coord,
    input  logic [COORD_W-1:0]   z_coord,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          robust_distance,
    output logic                 empty_flag,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data
);
    cfg_t cfg_reg;
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nearest_count <= K_W'(4);
            cfg_reg.scale_x       <= SCALE_W'(256);
            cfg_reg.scale_y       <= SCALE_W'(256);
            cfg_reg.scale_z       <= SCALE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEAREST: cfg_reg.nearest_count <= cfg_data[K_W-1:0];
                CFG_SCALE_X: cfg_reg.scale_x       <= cfg_data;
                CFG_SCALE_Y: cfg_reg.scale_y       <= cfg_data;
                CFG_SCALE_Z: cfg_reg.scale_z       <= cfg_data;
                default: ;
            endcase
        end
    end

    psrd_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .which_set(which_set),
        .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    psrd_back #(.MAX_POINTS(MAX_POINTS), .DIMENSIONS(DIMENSIONS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .robust_distance(robust_distance), .empty_flag(empty_flag)
    );

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_flag) |-> (robust_distance == 32'd0))
        else $error("empty result with nonzero distance");

    a_queue_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
        else $error("queue head lost while back end busy");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> cmd_valid)
        else $error("input stalled with empty queue");
endmodule

// ----- test/psrd_checker.sv -----
`timescale 1ns / 100ps

module psrd_checker
    import psrd_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic                 which_set,
    input  logic [COORD_W-1:0]   x_coord,
    input  logic [COORD_W-1:0]   y_coord,
    input  logic [COORD_W-1:0]   z_coord,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [31:0]          robust_distance,
    input  logic                 empty_flag,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct {
        logic [31:0] distance;
        logic        empty;
    } dist_result_t;

    logic [K_W-1:0]     k_reg;
    logic [SCALE_W-1:0] scale [3];

    // index 0 = query set, 1 = reference set
    int                 pts [2][MAX_POINTS][3];
    int                 cnt [2];
    int                 ctr [2][3];

    dist_result_t       expected_q [$];

    initial
    begin
        fail_count = 0;
        k_reg = 6'd4;
        scale[0] = 16'd256;
        scale[1] = 16'd256;
        scale[2] = 16'd256;
        cnt[0] = 0;
        cnt[1] = 0;
        for (int s = 0; s < 2; s++)
            for (int a = 0; a < 3; a++)
                ctr[s][a] = 0;
    end

    assign pending = expected_q.size();

    task automatic report(input string what, input longint unsigned exp_v,
                          input longint unsigned got_v);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
        fail_count++;
    endtask

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic int clamp20(input int v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic logic [63:0] pair_dist(input int qi, input int ri);
        logic [63:0] acc;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] term;
        int          d;
        acc = '0;
        for (int a = 0; a < 3; a++)
        begin
            d = pts[1][ri][a] - pts[0][qi][a];
            mag = (d < 0) ? 64'(-d) : 64'(d);
            t = mag * 64'(scale[a]);
            term = (t > 64'hFFFF_FFFF) ? {64{1'b1}} : t * t;
            acc = add_sat64(acc, term);
        end
        return acc;
    endfunction

    // restoring square root of s * 256
    function automatic logic [63:0] root_q16(input logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] bits2;
        rem = '0;
        root = '0;
        for (int i = 0; i < 36; i++)
        begin
            bits2 = (i < 32) ? ((s >> (62 - 2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | bits2;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic dist_result_t robust_dist();
        dist_result_t r;
        logic [63:0]  minima [$];
        logic [63:0]  best;
        logic [63:0]  d;
        logic [63:0]  sum;
        logic [63:0]  res;
        int           k;
        int           m;
        if (cnt[0] == 0 || cnt[1] == 0)
        begin
            r.distance = '0;
            r.empty = 1'b1;
            return r;
        end
        for (int i = 0; i < cnt[0]; i++)
        begin
            best = {64{1'b1}};
            for (int j = 0; j < cnt[1]; j++)
            begin
                d = pair_dist(i, j);
                if (d < best)
                    best = d;
            end
            minima.push_back(best);
        end
        minima.sort();
        k = (k_reg == 0) ? 1 : int'(k_reg);
        m = (k < cnt[0]) ? k : cnt[0];
        sum = '0;
        for (int i = 0; i < m; i++)
            sum = add_sat64(sum, minima[i]);
        res = root_q16(sum) / 64'(m);
        r.distance = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
        r.empty = 1'b0;
        return r;
    endfunction

    // sample at the falling edge: the values here are the ones the next rising edge takes
    always @(negedge clk)
    begin
        dist_result_t got;
        dist_result_t exp_r;
        int           s;
        int           c [3];
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NEAREST: k_reg = cfg_data[K_W-1:0];
                    CFG_SCALE_X: scale[0] = cfg_data;
                    CFG_SCALE_Y: scale[1] = cfg_data;
                    CFG_SCALE_Z: scale[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                s = which_set ? 1 : 0;
                c[0] = int'($signed(x_coord));
                c[1] = int'($signed(y_coord));
                c[2] = int'($signed(z_coord));
                case (operation)
                    OP_CENTER:
                        for (int a = 0; a < 3; a++)
                            ctr[s][a] = c[a];
                    OP_ADD:
                        if (cnt[s] < MAX_POINTS)
                        begin
                            for (int a = 0; a < 3; a++)
                                pts[s][cnt[s]][a] = clamp20(c[a] - ctr[s][a]);
                            cnt[s]++;
                        end
                    OP_COMPUTE:
                        expected_q.push_back(robust_dist());
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.distance = robust_distance;
                got.empty = empty_flag;
                if (expected_q.size() == 0)
                    report("unexpected result transfer", 0, got.distance);
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.distance !== exp_r.distance)
                        report("robust_distance", exp_r.distance, got.distance);
                    if (got.empty !== exp_r.empty)
                        report("empty_flag", exp_r.empty, got.empty);
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import psrd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 60000000;
    localparam int         HOLD_CYCLES = 3000;
    localparam logic [COORD_W-1:0] C_MAX = 20'h7FFFF;
    localparam logic [COORD_W-1:0] C_MIN = 20'h80000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           operation;
    logic                 which_set;
    logic [COORD_W-1:0]   x_coord;
    logic [COORD_W-1:0]   y_coord;
    logic [COORD_W-1:0]   z_coord;
    logic                 out_valid;
    logic                 out_ready;
    logic [31:0]          robust_distance;
    logic                 empty_flag;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int cycles;

    point_set_robust_distance i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .which_set       (which_set),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .robust_distance (robust_distance),
        .empty_flag      (empty_flag),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    psrd_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .which_set       (which_set),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .robust_distance (robust_distance),
        .empty_flag      (empty_flag),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_CENTER;
        which_set = 1'b0;
        x_coord = '0;
        y_coord = '0;
        z_coord = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_NEAREST;
        cfg_data = '0;
        tx_idle_pct = 25;
        rx_idle_pct = 52;
        hold_req = 1'b0;
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic [1:0] op, input logic set_sel,
                        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                        input logic [COORD_W-1:0] z);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        which_set <= set_sel;
        x_coord <= x;
        y_coord <= y;
        z_coord <= z;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let queued load transfers retire
        repeat (20) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return COORD_W'($urandom());
            default: return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    task automatic random_item();
        int          pick;
        logic [1:0]  op;
        logic        set_sel;
        pick = $urandom_range(0, 87);
        set_sel = 1'($urandom_range(0, 1));
        if (pick < 50)
            op = OP_CENTER;
        else if (pick < 80)
            op = OP_ADD;
        else if (pick < 84)
            op = OP_COMPUTE;
        else
            op = OP_UNUSED;
        send(op, set_sel, rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    task automatic random_run(input int items);
        for (int n = 0; n < items; n++)
            random_item();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty sets, coordinate saturation, scale and count extremes
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        send(OP_CENTER, 1'b0, C_MAX, C_MAX, C_MAX);
        send(OP_ADD, 1'b0, C_MIN, C_MIN, C_MIN);
        send(OP_COMPUTE, 1'b1, C_MAX, C_MIN, '0);
        send(OP_CENTER, 1'b1, C_MIN, C_MIN, C_MIN);
        send(OP_ADD, 1'b1, C_MAX, C_MAX, C_MAX);
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        send(OP_UNUSED, 1'b1, C_MAX, C_MAX, C_MAX);
        send(OP_CENTER, 1'b0, '0, '0, '0);
        send(OP_ADD, 1'b0, 20'd16, 20'hFFFF0, 20'd0);
        send(OP_CENTER, 1'b1, 20'd5, 20'd5, 20'd5);
        send(OP_ADD, 1'b1, 20'd5, 20'd5, 20'd5);
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        drain();
        set_reg(CFG_NEAREST, 16'd0);
        set_reg(CFG_SCALE_X, 16'hFFFF);
        set_reg(CFG_SCALE_Y, 16'hFFFF);
        set_reg(CFG_SCALE_Z, 16'hFFFF);
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        drain();
        set_reg(CFG_SCALE_X, 16'd0);
        set_reg(CFG_SCALE_Y, 16'd0);
        set_reg(CFG_SCALE_Z, 16'd0);
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        drain();
        set_reg(CFG_NEAREST, 16'd1);
        set_reg(CFG_SCALE_X, 16'd256);
        set_reg(CFG_SCALE_Y, 16'd128);
        set_reg(CFG_SCALE_Z, 16'd512);

        // long receiver hold-off while input keeps coming
        hold_req = 1'b1;
        send(OP_COMPUTE, 1'b0, '0, '0, '0);
        random_run(12);
        random_run(280);
        drain();

        set_reg(CFG_NEAREST, 16'd32);
        set_reg(CFG_SCALE_X, 16'd1);
        set_reg(CFG_SCALE_Y, 16'hFFFF);
        set_reg(CFG_SCALE_Z, 16'd300);
        tx_idle_pct = 52;
        rx_idle_pct = 25;
        random_run(300);
        drain();

        set_reg(CFG_NEAREST, 16'd63);
        set_reg(CFG_SCALE_X, 16'($urandom_range(0, 65535)));
        set_reg(CFG_SCALE_Y, 16'($urandom_range(0, 1023)));
        set_reg(CFG_SCALE_Z, 16'd256);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_run(300);
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
